>>> design/signed_int128_to_decimal_defines.svh
// Assertion macros for the signed binary to decimal text converter.
`ifndef SIGNED_INT128_TO_DECIMAL_DEFINES_SVH
`define SIGNED_INT128_TO_DECIMAL_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while in reset.
`define SITD_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, off while in reset.
`define SITD_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> design/sitd_pkg.sv
// Package: widths, character codes, state and control types of the converter.
`timescale 1ns / 1ps
`default_nettype none

package sitd_pkg;

    localparam int VALUE_BITS = 128;
    // digits of the largest magnitude, 2**(VALUE_BITS-1)
    localparam int NUM_DIGITS = ((VALUE_BITS - 1) * 30103) / 100000 + 1;
    localparam int BCD_BITS   = 4 * NUM_DIGITS;
    localparam int CNT_BITS   = $clog2(VALUE_BITS);

    localparam logic [5:0] CH_MINUS  = 6'd45;
    localparam logic [5:0] CH_ZERO   = 6'd48;
    localparam logic [3:0] ADJ_LIMIT = 4'd5;
    localparam logic [3:0] ADJ_ADD   = 4'd3;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CONVERT,
        ST_SIGN,
        ST_DIGITS
    } sitd_state_t;

    typedef struct packed {
        logic clear;
        logic shift_bit;
        logic bit_in;
        logic shift_digit;
    } sitd_bcd_ctl_t;

endpackage

`default_nettype wire

>>> design/sitd_bcd_core.sv
// Double-dabble BCD register: shifts in binary bits, shifts out decimal digits.
`timescale 1ns / 1ps
`default_nettype none

module sitd_bcd_core
    import sitd_pkg::*;
(
    input  wire logic          clk,
    input  wire sitd_bcd_ctl_t ctl,
    output logic [3:0]         top_digit
);

    logic [BCD_BITS-1:0] bcd_reg;
    logic [BCD_BITS-1:0] bcd_next;
    logic [BCD_BITS-1:0] adj;

    // add 3 to every digit of 5 or more before the doubling shift
    always_comb
    begin
        for (int i = 0; i < NUM_DIGITS; i++)
        begin
            if (bcd_reg[4*i +: 4] >= ADJ_LIMIT)
                adj[4*i +: 4] = bcd_reg[4*i +: 4] + ADJ_ADD;
            else
                adj[4*i +: 4] = bcd_reg[4*i +: 4];
        end
    end

    always_comb
    begin
        priority if (ctl.clear)
            bcd_next = '0;
        else if (ctl.shift_bit)
            bcd_next = {adj[BCD_BITS-2:0], ctl.bit_in};
        else if (ctl.shift_digit)
            bcd_next = {bcd_reg[BCD_BITS-5:0], 4'b0000};
        else
            bcd_next = bcd_reg;
    end

    always_ff @(posedge clk)
    begin
        bcd_reg <= bcd_next;
    end

    assign top_digit = bcd_reg[BCD_BITS-1 -: 4];

endmodule

`default_nettype wire

>>> design/signed_int128_to_decimal.sv
// Top level: signed 128-bit binary to decimal ASCII text, at most one char per cycle.
`timescale 1ns / 1ps
`default_nettype none

// Takes a signed two's-complement value on value_high/value_low when start is
// high and busy is low, then emits its decimal text most significant
// character first: a '-' for a negative value, then the digits with leading
// zeros dropped (zero gives a single '0'). Each character sits on text_char
// for exactly one cycle with strobe high; last_char marks the final one. The
// receiver cannot stall, so it must take every strobed character. Each value
// goes through bit-serial double-dabble over all VALUE_BITS (128) bits, a sign
// step, then NUM_DIGITS (39) steps that shift the BCD register one digit at a
// time. busy stays high through all of these, and the last character leaves
// in the cycle after busy falls; a new value may be started in that cycle.

module signed_int128_to_decimal
    import sitd_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               start,
    output logic                    busy,
    input  wire logic signed [63:0] value_high,
    input  wire logic        [63:0] value_low,
    output logic                    strobe,
    output logic             [5:0]  text_char,
    output logic                    last_char
);

`include "signed_int128_to_decimal_defines.svh"

    sitd_state_t state_reg;
    sitd_state_t state_next;

    logic [CNT_BITS-1:0]   cnt_reg;
    logic [CNT_BITS-1:0]   cnt_next;
    logic [VALUE_BITS-1:0] mag_reg;
    logic [VALUE_BITS-1:0] mag_next;
    logic                  neg_reg;
    logic                  neg_next;
    logic                  started_reg;
    logic                  started_next;

    logic                  strobe_reg;
    logic                  strobe_next;
    logic [5:0]            text_char_reg;
    logic [5:0]            text_char_next;
    logic                  last_char_reg;
    logic                  last_char_next;

    logic [127:0]          in_word;
    logic                  accept;
    logic                  mag_bit;
    logic [3:0]            top_digit;
    sitd_bcd_ctl_t         bcd_ctl;

    assign in_word = {value_high, value_low};
    assign busy    = (state_reg != ST_IDLE);
    assign accept  = start && !busy;

    // Magnitude bit, MSB first: a negated bit is the input bit flipped when any
    // lower bit is set. The most negative value thus yields 2**(VALUE_BITS-1).
    assign mag_bit = mag_reg[VALUE_BITS-1] ^ (neg_reg & (|mag_reg[VALUE_BITS-2:0]));

    sitd_bcd_core u_bcd
    (
        .clk       (clk),
        .ctl       (bcd_ctl),
        .top_digit (top_digit)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            strobe_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            strobe_reg <= strobe_next;
        end
    end

    // datapath registers, no reset needed
    always_ff @(posedge clk)
    begin
        cnt_reg       <= cnt_next;
        mag_reg       <= mag_next;
        neg_reg       <= neg_next;
        started_reg   <= started_next;
        text_char_reg <= text_char_next;
        last_char_reg <= last_char_next;
    end

    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        mag_next       = mag_reg;
        neg_next       = neg_reg;
        started_next   = started_reg;
        strobe_next    = 1'b0;
        text_char_next = text_char_reg;
        last_char_next = 1'b0;
        bcd_ctl        = '0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    mag_next      = in_word[VALUE_BITS-1:0];
                    neg_next      = in_word[VALUE_BITS-1];
                    cnt_next      = CNT_BITS'(VALUE_BITS - 1);
                    started_next  = 1'b0;
                    bcd_ctl.clear = 1'b1;
                    state_next    = ST_CONVERT;
                end
            end

            ST_CONVERT:
            begin
                bcd_ctl.shift_bit = 1'b1;
                bcd_ctl.bit_in    = mag_bit;
                mag_next          = {mag_reg[VALUE_BITS-2:0], 1'b0};
                if (cnt_reg == '0)
                    state_next = ST_SIGN;
                else
                    cnt_next = cnt_reg - CNT_BITS'(1);
            end

            ST_SIGN:
            begin
                strobe_next    = neg_reg;
                text_char_next = CH_MINUS;
                cnt_next       = CNT_BITS'(NUM_DIGITS - 1);
                state_next     = ST_DIGITS;
            end

            ST_DIGITS:
            begin
                // leading zeros are skipped; the units digit always goes out
                bcd_ctl.shift_digit = 1'b1;
                text_char_next      = CH_ZERO + {2'b00, top_digit};
                last_char_next      = (cnt_reg == '0);
                if (started_reg || (top_digit != 4'd0) || (cnt_reg == '0))
                begin
                    strobe_next  = 1'b1;
                    started_next = 1'b1;
                end
                if (cnt_reg == '0)
                    state_next = ST_IDLE;
                else
                    cnt_next = cnt_reg - CNT_BITS'(1);
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign strobe    = strobe_reg;
    assign text_char = text_char_reg;
    assign last_char = last_char_reg;

    // an accepted value always enters the conversion phase
    `SITD_ASSERT_NXT(a_accept_converts, accept,
        busy && (state_reg == ST_CONVERT), "accept did not start conversion")
    // the final character leaves after the block has gone idle
    `SITD_ASSERT_IMP(a_last_idle, strobe && last_char, !busy, "last character while still busy")
    // the sign is never the final character
    `SITD_ASSERT_IMP(a_sign_not_last, strobe && (text_char == CH_MINUS),
        !last_char, "minus sign flagged last")
    // no characters while converting
    `SITD_ASSERT_IMP(a_quiet_convert,
        $past(state_reg == ST_CONVERT) && (state_reg == ST_CONVERT),
        !strobe, "strobe during conversion")

endmodule

`default_nettype wire

>>> sim/signed_int128_to_decimal_checker.sv
// Checker: predicts the decimal text of each accepted value and compares every strobed char.
`timescale 1ns / 1ps

module signed_int128_to_decimal_checker
    import sitd_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic               busy,
    input  logic signed [63:0] value_high,
    input  logic        [63:0] value_low,
    input  logic               strobe,
    input  logic        [5:0]  text_char,
    input  logic               last_char,
    output int                 fail_count,
    output int                 pending
);

    typedef struct packed {
        logic [5:0] ch;
        logic       last;
    } text_sym_t;

    text_sym_t text_q[$];

    initial
    begin
        fail_count = 0;
        pending    = 0;
    end

    task automatic report_mismatch(input string msg);
        $display("%0t ns: mismatch: %s", $time, msg);
        fail_count++;
    endtask

    // Sign first, then digits most significant first; last flag on the final digit.
    task automatic queue_decimal_text(input logic [127:0] val);
        logic [127:0] mag;
        logic [3:0]   digs [0:39];
        int           nd;
        text_sym_t    sym;
        nd  = 0;
        mag = val[127] ? -val : val;
        do
        begin
            digs[nd] = 4'(mag % 128'd10);
            mag      = mag / 128'd10;
            nd++;
        end
        while (mag != 0);
        if (val[127])
        begin
            sym.ch   = CH_MINUS;
            sym.last = 1'b0;
            text_q.push_back(sym);
        end
        for (int i = nd - 1; i >= 0; i--)
        begin
            sym.ch   = CH_ZERO + 6'(digs[i]);
            sym.last = (i == 0);
            text_q.push_back(sym);
        end
    endtask

    always @(posedge clk)
    begin
        text_sym_t exp_sym;
        if (rst_n)
        begin
            // results of the previous value leave before a new one is queued
            if (strobe)
            begin
                if (text_q.size() == 0)
                    report_mismatch($sformatf("unexpected char %0d", text_char));
                else
                begin
                    exp_sym = text_q.pop_front();
                    if (text_char !== exp_sym.ch)
                        report_mismatch($sformatf("text_char %0d, expected %0d",
                                                  text_char, exp_sym.ch));
                    if (last_char !== exp_sym.last)
                        report_mismatch($sformatf("last_char %0b, expected %0b on char %0d",
                                                  last_char, exp_sym.last, exp_sym.ch));
                end
            end
            if (start && !busy)
                queue_decimal_text({value_high, value_low});
        end
        pending <= text_q.size();
    end

endmodule

>>> sim/tb_signed_int128_to_decimal.sv
// Testbench top: clock, reset, value stimulus and verdict for the decimal text converter.
`timescale 1ns / 1ps

module tb_signed_int128_to_decimal;

    localparam int PHASE_ITEMS = 87;

    logic               clk;
    logic               rst_n;
    logic               start;
    logic               busy;
    logic signed [63:0] value_high;
    logic        [63:0] value_low;
    logic               strobe;
    logic        [5:0]  text_char;
    logic               last_char;
    int                 fail_count;
    int                 pending;

    signed_int128_to_decimal u_top (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .value_high (value_high),
        .value_low  (value_low),
        .strobe     (strobe),
        .text_char  (text_char),
        .last_char  (last_char)
    );

    // Checker sees the same pins; it owns prediction and comparison.
    signed_int128_to_decimal_checker u_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .value_high (value_high),
        .value_low  (value_low),
        .strobe     (strobe),
        .text_char  (text_char),
        .last_char  (last_char),
        .fail_count (fail_count),
        .pending    (pending)
    );

    // 20 ns period
    initial clk = 1'b0;
    always #10 clk = ~clk;

    // Watchdog. Its timeout lies far beyond the length of a correct run.
    initial
    begin
        #10_000_000;
        $display("TB_ERROR");
        $finish;
    end

    // Offer one value, called at a falling edge. Each cycle the sender may idle
    // (start low) with the given percentage, so the idle cycles land anywhere,
    // including the cycles around the fall of busy. The transfer happens at the
    // rising edge where start is high and busy is low; returns at the next
    // falling edge. start gets one assignment per falling edge, never two.
    task automatic send_value(input logic [127:0] v, input int idle_pct);
        value_high <= v[127:64];
        value_low  <= v[63:0];
        forever
        begin
            start <= ($urandom_range(99) >= idle_pct);
            @(posedge clk);
            if (start && !busy)
                break;
            @(negedge clk);
        end
        @(negedge clk);
    endtask

    initial
    begin
        logic [127:0] v;
        logic [127:0] p;
        int           idle_pct;
        int           n;

        // every input known from time zero while reset is held low
        start      = 1'b0;
        value_high = '0;
        value_low  = '0;
        rst_n      = 1'b0;
        repeat (8) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Directed: zero, small values, digit carry at ten, the signed
        // extremes (most negative one included), the 64-bit boundary and
        // the widest text (39 digits plus sign).
        send_value(128'd0, 18);
        send_value(128'd1, 18);
        send_value(-128'd1, 18);
        send_value(128'd9, 18);
        send_value(128'd10, 18);
        send_value(-128'd10, 18);
        send_value(128'd123456789, 18);
        send_value({1'b0, {127{1'b1}}}, 18);
        send_value({1'b1, 127'd0}, 18);
        send_value({1'b1, 126'd0, 1'b1}, 18);
        send_value({64'd1, 64'd0}, 18);
        send_value({64'd0, {64{1'b1}}}, 18);
        send_value({{64{1'b1}}, 64'd0}, 18);
        send_value({64'h0f0f_0f0f_0f0f_0f0f, 64'hf0f0_f0f0_f0f0_f0f0}, 18);
        p = 128'd1;
        repeat (38) p = p * 128'd10;
        send_value(p, 18);
        send_value(p - 128'd1, 18);
        send_value(-p, 18);
        send_value(-(p - 128'd1), 18);

        // Random, three idle phases: sender idles 18%, then 76%, then never.
        for (int ph = 0; ph < 3; ph++)
        begin
            idle_pct = (ph == 0) ? 18 : (ph == 1) ? 76 : 0;
            for (int k = 0; k < PHASE_ITEMS; k++)
            begin
                v = {$urandom, $urandom, $urandom, $urandom};
                case ($urandom_range(9))
                    // any 128-bit pattern
                    0, 1, 2, 3: ;
                    // short magnitudes of random length and sign
                    4, 5, 6:
                    begin
                        n = $urandom_range(1, 127);
                        v = v >> (128 - n);
                        if ($urandom_range(1))
                            v = -v;
                    end
                    // around a power of ten, where the digit count changes
                    7, 8:
                    begin
                        p = 128'd1;
                        repeat ($urandom_range(38)) p = p * 128'd10;
                        v = p - 128'd1 + 128'($urandom_range(2));
                        if ($urandom_range(1))
                            v = -v;
                    end
                    // near the signed extremes and zero
                    default:
                    begin
                        n = $urandom_range(3);
                        v = (n == 0) ? {1'b1, 127'd0} :
                            (n == 1) ? {1'b0, {127{1'b1}}} :
                            (n == 2) ? 128'd0 : -128'd1;
                        v = v + 128'($urandom_range(2)) - 128'd1;
                    end
                endcase
                send_value(v, idle_pct);
            end
        end
        start <= 1'b0;

        // drain: all text out, then a wait for any stray strobe
        while (pending != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
        if (fail_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

>>> filelist.f
+incdir+design
design/sitd_pkg.sv
design/sitd_bcd_core.sv
design/signed_int128_to_decimal.sv
sim/signed_int128_to_decimal_checker.sv
sim/tb_signed_int128_to_decimal.sv
